>>> rtl/rpd_pkg.sv
package rpd_pkg;

  // Fixed field widths of the two channels
  localparam int SYM_W    = 8;
  localparam int PERIOD_W = 13;

  // Default table depth (bytes per string)
  localparam int DEFAULT_MAX_LEN = 4096;

  // Microprogram step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_ADMIT = 4'd1;
  localparam logic [STEP_W-1:0] S_CMP   = 4'd2;
  localparam logic [STEP_W-1:0] S_LINK  = 4'd3;
  localparam logic [STEP_W-1:0] S_STORE = 4'd4;
  localparam logic [STEP_W-1:0] S_DIVI  = 4'd5;
  localparam logic [STEP_W-1:0] S_DIV   = 4'd6;
  localparam logic [STEP_W-1:0] S_OUT   = 4'd7;
  localparam logic [STEP_W-1:0] S_OVF   = 4'd8;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH = 4'd1;
  localparam logic [OP_W-1:0] OP_ADMIT = 4'd2;
  localparam logic [OP_W-1:0] OP_CMP   = 4'd3;
  localparam logic [OP_W-1:0] OP_LINK  = 4'd4;
  localparam logic [OP_W-1:0] OP_STORE = 4'd5;
  localparam logic [OP_W-1:0] OP_OVF   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIVI  = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd8;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd9;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NO_BEAT  = 4'd2;
  localparam logic [COND_W-1:0] C_FULL     = 4'd3;
  localparam logic [COND_W-1:0] C_POS0     = 4'd4;
  localparam logic [COND_W-1:0] C_MATCH    = 4'd5;
  localparam logic [COND_W-1:0] C_JZERO    = 4'd6;
  localparam logic [COND_W-1:0] C_NOT_LAST = 4'd7;
  localparam logic [COND_W-1:0] C_SKIP     = 4'd8;
  localparam logic [COND_W-1:0] C_DIV_MORE = 4'd9;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd10;

  // One control word: ready flag, operation and two jump slots (first true wins)
  typedef struct packed {
    logic              in_rdy;
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond_a;
    logic [STEP_W-1:0] tgt_a;
    logic [COND_W-1:0] cond_b;
    logic [STEP_W-1:0] tgt_b;
  } ucw_t;

  // Control store
  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{in_rdy: 1'b0, op: OP_NONE, cond_a: C_ALWAYS, tgt_a: S_IDLE,
          cond_b: C_NEVER, tgt_b: S_IDLE};
    case (step)
      S_IDLE:  w = '{1'b1, OP_LATCH, C_NO_BEAT,  S_IDLE,  C_NEVER,  S_IDLE};
      S_ADMIT: w = '{1'b0, OP_ADMIT, C_FULL,     S_OVF,   C_POS0,   S_STORE};
      S_CMP:   w = '{1'b0, OP_CMP,   C_MATCH,    S_STORE, C_JZERO,  S_STORE};
      S_LINK:  w = '{1'b0, OP_LINK,  C_ALWAYS,   S_CMP,   C_NEVER,  S_IDLE};
      S_STORE: w = '{1'b0, OP_STORE, C_NOT_LAST, S_IDLE,  C_NEVER,  S_IDLE};
      S_DIVI:  w = '{1'b0, OP_DIVI,  C_SKIP,     S_OUT,   C_NEVER,  S_IDLE};
      S_DIV:   w = '{1'b0, OP_DIV,   C_DIV_MORE, S_DIV,   C_NEVER,  S_IDLE};
      S_OUT:   w = '{1'b0, OP_OUT,   C_OUT_BUSY, S_OUT,   C_ALWAYS, S_IDLE};
      S_OVF:   w = '{1'b0, OP_OVF,   C_NOT_LAST, S_IDLE,  C_ALWAYS, S_DIVI};
      default: w = '{1'b0, OP_NONE,  C_ALWAYS,   S_IDLE,  C_NEVER,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/rpd_if.sv
// Byte channel into the detector
interface rpd_in_if import rpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// Result channel out of the detector
interface rpd_out_if import rpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                repeated;
  logic [PERIOD_W-1:0] period;
  logic                overflow;

  modport source (output valid, output repeated, output period, output overflow,
                  input ready);
  modport sink   (input valid, input repeated, input period, input overflow,
                  output ready);
endinterface

>>> rtl/rpd_ram.sv
module rpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/repeated_pattern_detector.sv
// Repeated pattern detector. Bytes of a string arrive one beat at a time on
// in_bus, the final byte flagged by last. The block builds the KMP prefix
// function as the bytes come in and, after the last byte, returns one beat on
// out_bus: repeated is 1 when the string is a shorter block repeated two or
// more times, period is the smallest period (length minus the final prefix
// value) and overflow is 1 when the string ran past MAX_LEN bytes (then
// repeated is 0 and period is 0; extra bytes are dropped). A small microcoded
// sequencer drives the datapath and processes one byte at a time, through
// latch, admit, compare and store steps. Each failure link followed adds a
// read of the prefix table and then of the byte store, since each has a
// single read port. Links followed are bounded in total by the bytes seen.
// After the last byte a bit-serial remainder unit checks the length against
// the period, unless the string overflowed or its final prefix value is 0. No
// clearing pass is needed after reset; the block accepts bytes as soon as
// reset is released. A result waiting in the output register does not hold up
// the next string until that string's own result is due.
module repeated_pattern_detector import rpd_pkg::*; #(
  parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst_n,
  rpd_in_if.sink    in_bus,
  rpd_out_if.source out_bus
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(PW + 1);

  // Sequencer
  logic [STEP_W-1:0] upc_r, upc_nxt;
  ucw_t              ucw;

  // Datapath registers
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [AW-1:0]    match_len_r, match_len_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic [PW-1:0]    per_r, per_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_rep_r, out_rep_nxt;
  logic [PERIOD_W-1:0] out_per_r, out_per_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Memory ports
  logic             cs_we;
  logic [AW-1:0]    cs_raddr;
  logic [SYM_W-1:0] cs_rdata;
  logic             pt_we;
  logic [AW-1:0]    pt_raddr;
  logic [AW-1:0]    pt_rdata;

  // Status
  logic              beat;
  logic              pos_full;
  logic              match;
  logic              out_busy;
  logic              take_a;
  logic              take_b;
  logic [PW:0]       trial;
  logic [PW+PERIOD_W-1:0] per_ext;

  assign ucw      = ucode_rom(upc_r);
  assign beat     = in_bus.valid && ucw.in_rdy;
  assign pos_full = (pos_r == PW'(MAX_LEN));
  assign match    = (cs_rdata == sym_r);
  assign out_busy = out_valid_r && !out_bus.ready;
  assign trial    = {rem_r, quo_r[PW-1]};
  assign per_ext  = {{PERIOD_W{1'b0}}, per_r};

  // Evaluate a jump condition
  function automatic logic cond_true(input logic [COND_W-1:0] c, input logic in_valid,
                                     input logic full, input logic pos0,
                                     input logic eq, input logic jzero,
                                     input logic is_last, input logic skip,
                                     input logic more, input logic busy);
    logic r;
    case (c)
      C_NEVER:    r = 1'b0;
      C_ALWAYS:   r = 1'b1;
      C_NO_BEAT:  r = !in_valid;
      C_FULL:     r = full;
      C_POS0:     r = pos0;
      C_MATCH:    r = eq;
      C_JZERO:    r = jzero;
      C_NOT_LAST: r = !is_last;
      C_SKIP:     r = skip;
      C_DIV_MORE: r = more;
      C_OUT_BUSY: r = busy;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // Pick the next step: first jump slot, second slot, else fall through
  always_comb begin
    take_a = cond_true(ucw.cond_a, in_bus.valid, pos_full, pos_r == '0, match, j_r == '0,
                       last_r, ovf_r || (match_len_r == '0), cnt_r != CW'(1), out_busy);
    take_b = cond_true(ucw.cond_b, in_bus.valid, pos_full, pos_r == '0, match, j_r == '0,
                       last_r, ovf_r || (match_len_r == '0), cnt_r != CW'(1), out_busy);
    if (take_a) begin
      upc_nxt = ucw.tgt_a;
    end else if (take_b) begin
      upc_nxt = ucw.tgt_b;
    end else begin
      upc_nxt = upc_r + STEP_W'(1);
    end
  end

  // Memory addressing
  assign cs_we    = (ucw.op == OP_ADMIT) && !pos_full;
  assign cs_raddr = (ucw.op == OP_LINK) ? pt_rdata : j_r;
  assign pt_we    = (ucw.op == OP_STORE);
  assign pt_raddr = j_r - AW'(1);

  // Datapath operations
  always_comb begin
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    match_len_nxt = match_len_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    per_nxt       = per_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_rep_nxt   = out_rep_r;
    out_per_nxt   = out_per_r;
    out_ovf_nxt   = out_ovf_r;
    case (ucw.op)
      OP_LATCH: begin
        if (beat) begin
          sym_nxt  = in_bus.symbol;
          last_nxt = in_bus.last;
          j_nxt    = match_len_r;
        end
      end
      OP_CMP: begin
        // extend the match on equal bytes
        if (match) begin
          j_nxt = j_r + AW'(1);
        end
      end
      OP_LINK: begin
        // follow the failure link
        j_nxt = pt_rdata;
      end
      OP_STORE: begin
        match_len_nxt = j_r;
        pos_nxt       = pos_r + PW'(1);
      end
      OP_OVF: begin
        ovf_nxt = 1'b1;
      end
      OP_DIVI: begin
        per_nxt = pos_r - PW'(match_len_r);
        rem_nxt = '0;
        quo_nxt = pos_r;
        cnt_nxt = CW'(PW);
      end
      OP_DIV: begin
        // one restoring remainder step per cycle
        if (trial >= {1'b0, per_r}) begin
          rem_nxt = PW'(trial - {1'b0, per_r});
        end else begin
          rem_nxt = trial[PW-1:0];
        end
        quo_nxt = quo_r << 1;
        cnt_nxt = cnt_r - CW'(1);
      end
      OP_OUT: begin
        // load the result and clear for the next string
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_rep_nxt   = !ovf_r && (match_len_r != '0) && (rem_r == '0);
          out_per_nxt   = ovf_r ? '0 : per_ext[PERIOD_W-1:0];
          out_ovf_nxt   = ovf_r;
          match_len_nxt = '0;
          pos_nxt       = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      match_len_r <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      match_len_r <= match_len_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    last_r    <= last_nxt;
    j_r       <= j_nxt;
    per_r     <= per_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    out_rep_r <= out_rep_nxt;
    out_per_r <= out_per_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // Byte store
  rpd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_char_store (
    .clk   (clk),
    .we    (cs_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (sym_r),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  // Prefix table
  rpd_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_LEN)
  ) u_prefix_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (j_r),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  assign in_bus.ready     = ucw.in_rdy;
  assign out_bus.valid    = out_valid_r;
  assign out_bus.repeated = out_rep_r;
  assign out_bus.period   = out_per_r;
  assign out_bus.overflow = out_ovf_r;

  // Overflow is only flagged once the table is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_full)
    else $error("overflow flag set while table not full");

  // Between bytes the match stays shorter than the string
  a_match_short: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_IDLE && pos_r != '0) |-> (PW'(match_len_r) < pos_r))
    else $error("match length not below position");

  // Compared byte lies inside the part already stored
  a_cmp_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_CMP) |-> (PW'(j_r) < pos_r))
    else $error("compare index beyond stored bytes");

  // Remainder loop never runs with an exhausted count
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_DIV) |-> (cnt_r != '0))
    else $error("remainder step with zero count");

endmodule

>>> dv/testbench.sv
module testbench;
  import rpd_pkg::*;

  localparam int DEPTH        = DEFAULT_MAX_LEN;
  localparam int PFX_W        = 12;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 40;
  localparam int SHOW_MAX     = 10;

  typedef struct packed {
    logic                repeated;
    logic [PERIOD_W-1:0] period;
    logic                overflow;
  } verdict_t;

  // Online prefix function per string and the queue of verdicts still owed
  class verdict_tracker;
    verdict_t         due[$];
    logic [PFX_W-1:0] pfx_len [DEPTH];
    logic [SYM_W-1:0] held [DEPTH];
    int unsigned      match_len = 0;
    int unsigned      fill = 0;
    bit               spilled = 1'b0;
    int               errors = 0;
    int               shown = 0;

    function void take_byte(logic [SYM_W-1:0] c, logic lst);
      int unsigned j;
      int unsigned len;
      int unsigned per;
      verdict_t    v;
      // Drop bytes past the table, but remember the string ran long
      if (fill >= DEPTH) begin
        spilled = 1'b1;
      end else begin
        held[fill] = c;
        j = 0;
        if (fill != 0) begin
          j = match_len;
          // Follow failure links until the next byte of the match agrees
          while (j > 0 && c != held[j]) j = pfx_len[j-1];
          if (c == held[j]) j++;
        end
        pfx_len[fill] = PFX_W'(j);
        match_len = j;
        fill++;
      end
      if (!lst) return;
      if (spilled) begin
        v = '{repeated: 1'b0, period: '0, overflow: 1'b1};
      end else begin
        len = fill;
        per = len - match_len;
        v.repeated = (match_len != 0) && (len % per == 0);
        v.period   = PERIOD_W'(per);
        v.overflow = 1'b0;
      end
      due.push_back(v);
      // Start over for the next string
      match_len = 0;
      fill      = 0;
      spilled   = 1'b0;
    endfunction

    function void report(string what, verdict_t want, verdict_t got);
      errors++;
      if (shown < SHOW_MAX) begin
        shown++;
        $display("%0t: %s: expected rep=%0b per=%0d ovf=%0b, got rep=%0b per=%0d ovf=%0b",
                 $time, what, want.repeated, want.period, want.overflow,
                 got.repeated, got.period, got.overflow);
      end
    endfunction

    function void check_verdict(logic rep, logic [PERIOD_W-1:0] per, logic ovf);
      verdict_t got;
      verdict_t want;
      got = '{repeated: rep, period: per, overflow: ovf};
      if (due.size() == 0) begin
        report("result with nothing due", '0, got);
        return;
      end
      want = due.pop_front();
      if (got.repeated !== want.repeated || got.period !== want.period ||
          got.overflow !== want.overflow)
        report("result mismatch", want, got);
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Count verdicts that never arrived and return the failure total
    function int close_out();
      if (due.size() != 0) begin
        errors += due.size();
        $display("%0t: %0d result(s) never arrived", $time, due.size());
      end
      return errors;
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rpd_in_if  in_bus ();
  rpd_out_if out_bus ();

  repeated_pattern_detector #(.MAX_LEN(DEPTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  verdict_tracker   tracker;
  logic [SYM_W-1:0] text[$];
  bit               in_gaps_on  = 1'b1;
  bit               out_gaps_on = 1'b1;
  int               beats_taken = 0;

  always #1 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("** repeated_pattern_detector: FAILED **");
    $finish;
  end

  // Note every accepted byte and check every accepted result
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      tracker.take_byte(in_bus.symbol, in_bus.last);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tracker.check_verdict(out_bus.repeated, out_bus.period, out_bus.overflow);
  end

  // Result side: random stalls, one long hold-off so the block backs up
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (beats_taken == HOLD_AT)
        repeat (HOLD_CYCLES) @(negedge clk) out_bus.ready <= 1'b0;
      gap = out_gaps_on ? $urandom_range(0, 3) : 0;
      repeat (gap) @(negedge clk) out_bus.ready <= 1'b0;
      @(negedge clk) out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      beats_taken++;
      if ($urandom_range(0, 15) == 0) out_gaps_on = !out_gaps_on;
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic put_byte(input logic [SYM_W-1:0] sym, input logic lst);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) @(negedge clk) in_bus.valid <= 1'b0;
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.symbol <= sym;
    in_bus.last   <= lst;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_text();
    foreach (text[i]) put_byte(text[i], i == text.size() - 1);
    if ($urandom_range(0, 19) == 0) in_gaps_on = !in_gaps_on;
  endtask

  // Stop offering until every owed verdict has come back
  task automatic drain();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick(bit narrow, logic [SYM_W-1:0] a,
                                            logic [SYM_W-1:0] b);
    if (narrow) return $urandom_range(0, 1) ? a : b;
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // Build a string: mostly repeated blocks, some damaged, some plain noise
  task automatic make_random_text();
    logic [SYM_W-1:0] blk[$];
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    int               kind;
    int               blen;
    int               reps;
    int               extra;
    bit               narrow;
    text.delete();
    a      = SYM_W'($urandom_range(0, 255));
    b      = SYM_W'($urandom_range(0, 255));
    narrow = $urandom_range(0, 2) != 0;
    kind   = $urandom_range(0, 9);
    if (kind <= 6) begin
      blen = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      reps = $urandom_range(1, 6);
      repeat (blen) blk.push_back(pick(narrow, a, b));
      repeat (reps) foreach (blk[i]) text.push_back(blk[i]);
      case ($urandom_range(0, 5))
        0: text[$urandom_range(0, text.size() - 1)] = SYM_W'($urandom_range(0, 255));
        1: begin
          extra = $urandom_range(1, blen);
          for (int i = 0; i < extra; i++) text.push_back(blk[i]);
        end
        2: if (text.size() > 1) void'(text.pop_back());
        default: ;
      endcase
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 32)) text.push_back(pick(narrow, a, b));
    end else begin
      // Runs of one byte then another: long failure-link chains
      blen = $urandom_range(1, 10);
      reps = $urandom_range(1, 4);
      repeat (reps) begin
        repeat (blen) text.push_back(a);
        text.push_back(b);
      end
    end
  endtask

  initial begin
    int sent;
    int strings;
    int failures;

    in_bus.valid  = 1'b0;
    in_bus.symbol = '0;
    in_bus.last   = 1'b0;
    tracker = new;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: single byte, byte extremes, short and partial periods
    text = '{8'hFF};                               send_text();
    text = '{8'h00, 8'h00};                        send_text();
    text = '{8'h55, 8'hAA, 8'h55, 8'hAA};          send_text();
    text = '{8'h01, 8'h02, 8'h01};                 send_text();
    text = '{8'hAA, 8'hAA, 8'hAB};                 send_text();
    text = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h62}; send_text();
    text = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80};   send_text();
    drain();

    // Random strings, with one pause until everything has drained
    sent    = 0;
    strings = 0;
    while (sent < RANDOM_ITEMS) begin
      make_random_text();
      send_text();
      sent += text.size();
      strings++;
      if (strings == 60) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    failures = tracker.close_out();
    if (failures == 0)
      $display("** repeated_pattern_detector: PASSED **");
    else
      $display("** repeated_pattern_detector: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/rpd_pkg.sv
rtl/rpd_if.sv
rtl/rpd_ram.sv
rtl/repeated_pattern_detector.sv
dv/testbench.sv
